/* rtl/sbtx_pkg.sv */
package sbtx_pkg;

    // Frame bit indexes: start bit is 0, data bits 1..8, stop bit 9
    localparam logic [3:0] FRAME_LAST_BIT = 4'd9;

    // Break length limits, in bit periods
    localparam logic [4:0] BREAK_MIN   = 5'd13;
    localparam logic [4:0] BREAK_RESET = 5'd15;

    // Input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register map
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic        REG_BREAK_BITS = 1'b0;   // word index in paddr[2]

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FRAME = 2'd1,
        MODE_BREAK = 2'd2
    } t_mode;

    typedef struct packed {
        logic       drive_line;
        logic       busy_res;
        logic       done_res;
        logic       collided;
        logic [3:0] collision_bit;
    } t_result;

endpackage

/* rtl/sbtx_apb_regs.sv */
module sbtx_apb_regs
    import sbtx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [4:0]            o_break_bits
);

    logic [4:0] r_break_bits;
    logic       w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_bits <= BREAK_RESET;
        end else if (w_write && (paddr[2] == REG_BREAK_BITS)) begin
            r_break_bits <= pwdata[4:0];
        end
    end

    // low address bits carry no register; ignore them
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_BREAK_BITS) begin
            prdata = {{(CFG_DATA_W-5){1'b0}}, r_break_bits};
        end
    end

    assign o_break_bits = r_break_bits;

endmodule

/* rtl/sbtx_core.sv */
module sbtx_core
    import sbtx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic       i_operation,
    input  logic [7:0] i_tx_byte,
    input  logic       i_line_in,
    input  logic [4:0] i_break_bits,
    output t_result    o_result
);

    t_mode      r_mode,        n_mode;
    logic [7:0] r_data_shift,  n_data_shift;
    logic [3:0] r_bit_index,   n_bit_index;
    logic       r_second_half, n_second_half;
    logic       r_error_seen,  n_error_seen;
    logic [3:0] r_error_index, n_error_index;
    logic [5:0] r_break_count, n_break_count;
    logic       r_drive_reg,   n_drive_reg;

    logic       w_start;
    logic       w_tick;
    logic [4:0] w_brk;
    logic [5:0] w_break_inc;
    logic       w_break_end;
    logic [3:0] w_next_index;
    logic       w_done;
    logic       w_coll;
    logic [3:0] w_cbit;

    // Bus level while frame bit k is on the line
    function automatic logic expected_level(input logic [3:0] k, input logic [7:0] d);
        logic [2:0] sel;
        sel = k[2:0] - 3'd1;
        if (k == 4'd0) begin
            return 1'b0;
        end else if (k >= FRAME_LAST_BIT) begin
            return 1'b1;
        end else begin
            return d[sel];
        end
    endfunction

    assign w_start      = i_fire && (i_operation == OP_START);
    assign w_tick       = i_fire && (i_operation == OP_TICK);
    assign w_brk        = (i_break_bits < BREAK_MIN) ? BREAK_MIN : i_break_bits;
    assign w_break_inc  = r_break_count + 6'd1;
    assign w_break_end  = (w_break_inc >= {1'b0, w_brk});
    assign w_next_index = r_bit_index + 4'd1;

    // Next state
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_IDLE: begin
                if (w_start) begin
                    n_mode = MODE_FRAME;
                end
            end
            MODE_FRAME: begin
                if (w_tick && r_second_half) begin
                    if (r_error_seen) begin
                        n_mode = MODE_BREAK;
                    end else if (r_bit_index >= FRAME_LAST_BIT) begin
                        n_mode = MODE_IDLE;
                    end
                end
            end
            MODE_BREAK: begin
                if (w_tick && r_second_half && w_break_end) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
    end

    // Datapath and result
    always_comb begin
        n_data_shift  = r_data_shift;
        n_bit_index   = r_bit_index;
        n_second_half = r_second_half;
        n_error_seen  = r_error_seen;
        n_error_index = r_error_index;
        n_break_count = r_break_count;
        n_drive_reg   = r_drive_reg;
        w_done        = 1'b0;
        w_coll        = 1'b0;
        w_cbit        = 4'd0;
        case (r_mode)
            MODE_IDLE: begin
                if (w_start) begin
                    n_data_shift  = i_tx_byte;
                    n_bit_index   = 4'd0;
                    n_second_half = 1'b0;
                    n_error_seen  = 1'b0;
                    n_error_index = 4'd0;
                    n_break_count = 6'd0;
                    n_drive_reg   = 1'b1;
                end
            end
            MODE_FRAME: begin
                if (w_tick) begin
                    if (!r_second_half) begin
                        // mid-bit: sample the bus, latch only the first mismatch
                        if (!r_error_seen &&
                            (i_line_in != expected_level(r_bit_index, r_data_shift))) begin
                            n_error_seen  = 1'b1;
                            n_error_index = r_bit_index;
                        end
                        n_second_half = 1'b1;
                    end else begin
                        n_second_half = 1'b0;
                        if (r_error_seen) begin
                            n_break_count = 6'd0;
                            n_drive_reg   = 1'b1;
                        end else if (r_bit_index >= FRAME_LAST_BIT) begin
                            n_drive_reg = 1'b0;
                            w_done      = 1'b1;
                        end else begin
                            n_bit_index = w_next_index;
                            n_drive_reg = ~expected_level(w_next_index, r_data_shift);
                        end
                    end
                end
            end
            MODE_BREAK: begin
                if (w_tick) begin
                    if (!r_second_half) begin
                        n_second_half = 1'b1;
                    end else begin
                        n_second_half = 1'b0;
                        n_break_count = w_break_inc;
                        if (w_break_end) begin
                            n_drive_reg = 1'b0;
                            w_done      = 1'b1;
                            w_coll      = 1'b1;
                            w_cbit      = r_error_index;
                        end else begin
                            n_drive_reg = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_drive_reg = r_drive_reg;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_data_shift  <= 8'd0;
            r_bit_index   <= 4'd0;
            r_second_half <= 1'b0;
            r_error_seen  <= 1'b0;
            r_error_index <= 4'd0;
            r_break_count <= 6'd0;
            r_drive_reg   <= 1'b0;
        end else if (i_fire) begin
            r_mode        <= n_mode;
            r_data_shift  <= n_data_shift;
            r_bit_index   <= n_bit_index;
            r_second_half <= n_second_half;
            r_error_seen  <= n_error_seen;
            r_error_index <= n_error_index;
            r_break_count <= n_break_count;
            r_drive_reg   <= n_drive_reg;
        end
    end

    always_comb begin
        o_result.drive_line    = n_drive_reg;
        o_result.busy_res      = (n_mode != MODE_IDLE);
        o_result.done_res      = w_done;
        o_result.collided      = w_coll;
        o_result.collision_bit = w_cbit;
    end

    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE) |-> !r_drive_reg)
        else $error("line driven while idle");

    a_break_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_BREAK) |-> (r_drive_reg && r_error_seen))
        else $error("break without drive or without a recorded collision");

    a_bit_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_FRAME) |-> (r_bit_index <= FRAME_LAST_BIT))
        else $error("frame bit index past stop bit");

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_done) |=> (r_mode == MODE_IDLE))
        else $error("done without return to idle");

endmodule

/* rtl/serial_byte_tx_collision_detect_unit.sv */
// Byte transmitter for a shared single-wire bus, with collision detection.
// Input channel (i_in_valid / o_in_stall): operation 0 loads i_tx_byte and
// starts a frame when idle; operation 1 is a half-bit tick carrying the sensed
// bus level i_line_in. Every accepted item yields exactly one result on the
// output channel (o_out_valid / i_out_stall): pin level, busy, done, and on
// done whether a collision was seen and at which frame bit.
// An item taken into the input register passes through the frame/break state
// update into the result register when that register is free or draining, and
// o_out_valid rises with the registered result.
// Throughput is one item per clock while the output is not stalled; the state
// update is a single pass of compare-and-select logic.
// A stall on the output holds the result register; the input register still
// takes one more item if empty, then o_in_stall rises, and nothing is dropped.
// Synchronous reset returns to idle with the line released and break_bits at
// 15. The break_bits register (APB, address 0) is meant to be written only
// while no item is in flight; values below 13 act as 13.
module serial_byte_tx_collision_detect_unit
    import sbtx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  logic [7:0]            i_tx_byte,
    input  logic                  i_line_in,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_drive_line,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic                  o_collided,
    output logic [3:0]            o_collision_bit,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic       r_in_valid;
    logic       r_in_operation;
    logic [7:0] r_in_tx_byte;
    logic       r_in_line_in;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_advance;
    logic [4:0] w_break_bits;
    t_result    w_result;

    // process the held item when the result register is free or draining
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_operation <= i_operation;
            r_in_tx_byte   <= i_tx_byte;
            r_in_line_in   <= i_line_in;
        end
    end

    sbtx_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_break_bits (w_break_bits)
    );

    sbtx_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_advance),
        .i_operation  (r_in_operation),
        .i_tx_byte    (r_in_tx_byte),
        .i_line_in    (r_in_line_in),
        .i_break_bits (w_break_bits),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_line    = r_out.drive_line;
    assign o_busy_res      = r_out.busy_res;
    assign o_done_res      = r_out.done_res;
    assign o_collided      = r_out.collided;
    assign o_collision_bit = r_out.collision_bit;

endmodule
